[rtl/core/sfr_pkg.sv]
// Shared types and constants of the stream find-and-replace block.
// Used by the channel interfaces, the result buffer and the top level.
package sfr_pkg;

   // Byte and slot geometry of the result buffer
   localparam int SFR_BYTE_W = 8;
   localparam int SFR_SLOTS  = 8;
   localparam int SFR_CNT_W  = 4;
   localparam int SFR_IDX_W  = 3;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_PATTERN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_TEXT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_EVERY      = 3'd4;

   typedef logic [SFR_BYTE_W-1:0] sfr_byte_type;

   // One burst of result words handed to the result buffer
   typedef struct packed {
      logic                              load;
      logic [SFR_CNT_W-1:0]              count;
      logic [SFR_SLOTS-1:0][SFR_BYTE_W-1:0] bytes;
      logic                              byte_valid;
      logic                              last;
   } sfr_load_type;

endpackage

[rtl/core/sfr_if.sv]
// Valid/ready channel interfaces for text words in and result words out.
// Depend on sfr_pkg for the byte type.
interface sfr_req_if;
   logic                 valid;
   logic                 ready;
   sfr_pkg::sfr_byte_type text_byte;
   logic                 text_end;

   modport source (output valid, output text_byte, output text_end, input ready);
   modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface sfr_rsp_if;
   logic                 valid;
   logic                 ready;
   sfr_pkg::sfr_byte_type out_byte;
   logic                 byte_valid;
   logic                 out_last;

   modport source (output valid, output out_byte, output byte_valid, output out_last,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                   output ready);
endinterface

[rtl/core/sfr_result_buffer.sv]
// Result buffer: holds up to eight result words of one input word and
// hands them out one per cycle while the result channel is ready. Depends on sfr_pkg and sfr_rsp_if.
module sfr_result_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  sfr_pkg::sfr_load_type ld,
   output logic                  free_next,
   sfr_rsp_if.source             rsp_ch
);
   import sfr_pkg::*;

   sfr_byte_type             bytes_ff [SFR_SLOTS];
   sfr_byte_type             bytes_in [SFR_SLOTS];
   logic [SFR_CNT_W-1:0]     left_ff, left_in;
   logic [SFR_IDX_W-1:0]     idx_ff, idx_in;
   logic                     last_ff, last_in;
   logic                     bvalid_ff, bvalid_in;
   logic                     rsp_fire;

   // Drive the result channel from the current slot
   always_comb begin
      rsp_ch.valid      = (left_ff != '0);
      rsp_ch.out_byte   = bytes_ff[idx_ff];
      rsp_ch.byte_valid = bvalid_ff;
      rsp_ch.out_last   = last_ff && (left_ff == SFR_CNT_W'(1));
   end

   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign free_next = (left_ff == '0) || ((left_ff == SFR_CNT_W'(1)) && rsp_ch.ready);

   // Load a new burst or advance through the current one
   always_comb begin
      bytes_in  = bytes_ff;
      left_in   = left_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      bvalid_in = bvalid_ff;
      if (ld.load) begin
         for (int i = 0; i < SFR_SLOTS; i++) begin
            bytes_in[i] = ld.bytes[i];
         end
         left_in   = ld.count;
         idx_in    = '0;
         last_in   = ld.last;
         bvalid_in = ld.byte_valid;
      end else if (rsp_fire) begin
         left_in = left_ff - SFR_CNT_W'(1);
         idx_in  = idx_ff + SFR_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff  <= bytes_in;
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      bvalid_ff <= bvalid_in;
   end

`ifndef SYNTH
   // A burst never lands on words still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ld.load |-> (left_ff == '0) || ((left_ff == SFR_CNT_W'(1)) && rsp_fire))
      else $error("result buffer loaded while words were pending");

   // The marked word empties the buffer
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_ch.out_last && !ld.load |=> left_ff == '0)
      else $error("words left after the last word of a text");

   // An empty marker is always the last word
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.byte_valid |-> rsp_ch.out_last)
      else $error("empty marker without end mark");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      left_ff <= SFR_CNT_W'(SFR_SLOTS))
      else $error("result buffer count beyond its depth");
`endif

endmodule

[rtl/core/stream_find_replace_unit.sv]
// Stream find-and-replace: input register, pending window and match logic,
// feeding the result buffer. Depends on sfr_pkg, sfr_if and sfr_result_buffer.
// Flow: an accepted word waits in the input register until the result buffer is
//   free; its result words are then loaded into the buffer and offered from it.
// Throughput: one input word per cycle while each yields at most one result and
//   the result channel is ready; a word with more results holds back the next one.
// Reset (synchronous, active high): registers to their defaults, window empty.
module stream_find_replace_unit #(
   parameter int MAX_PATTERN     = 8,
   parameter int MAX_REPLACEMENT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   sfr_req_if.sink                         req_ch,
   sfr_rsp_if.source                       rsp_ch
);
   import sfr_pkg::*;

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);

   // Configuration registers
   logic [CSR_DATA_W-1:0] pattern_ff;
   logic [SFR_CNT_W-1:0]  plen_raw_ff;
   logic [CSR_DATA_W-1:0] repl_ff;
   logic [SFR_CNT_W-1:0]  rlen_raw_ff;
   logic                  every_ff;

   // Input register
   logic         in_valid_ff, in_valid_in;
   sfr_byte_type in_byte_ff, in_byte_in;
   logic         in_end_ff, in_end_in;

   // Pending window state
   sfr_byte_type win_ff [MAX_PATTERN];
   sfr_byte_type win_in [MAX_PATTERN];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   // Working signals
   sfr_byte_type         wprime [MAX_PATTERN];
   logic [SFR_CNT_W-1:0] plen_eff, rlen_eff, cnt_ext, n_len;
   logic [CNT_W-1:0]     cnt_cur;
   logic                 buf_free, proc_fire, req_fire, hit, full, passing;
   sfr_load_type         ld;

   // Write configuration registers; a new pattern length drops the window
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         plen_raw_ff <= SFR_CNT_W'(1);
         repl_ff     <= '0;
         rlen_raw_ff <= '0;
         every_ff    <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SEARCH_PATTERN:     pattern_ff  <= csr_wr_data;
            CSR_PATTERN_LENGTH:     plen_raw_ff <= csr_wr_data[SFR_CNT_W-1:0];
            CSR_REPLACEMENT_TEXT:   repl_ff     <= csr_wr_data;
            CSR_REPLACEMENT_LENGTH: rlen_raw_ff <= csr_wr_data[SFR_CNT_W-1:0];
            CSR_REPLACE_EVERY:      every_ff    <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Clamp lengths to what the window and buffer hold; a zero pattern length acts as one
   always_comb begin
      if (plen_raw_ff == '0) begin
         plen_eff = SFR_CNT_W'(1);
      end else if (plen_raw_ff > SFR_CNT_W'(MAX_PATTERN)) begin
         plen_eff = SFR_CNT_W'(MAX_PATTERN);
      end else begin
         plen_eff = plen_raw_ff;
      end
      if (rlen_raw_ff > SFR_CNT_W'(MAX_REPLACEMENT)) begin
         rlen_eff = SFR_CNT_W'(MAX_REPLACEMENT);
      end else begin
         rlen_eff = rlen_raw_ff;
      end
   end

   // Input register handshake
   assign proc_fire    = in_valid_ff && buf_free;
   assign req_ch.ready = !in_valid_ff || proc_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.text_byte;
         in_end_in   = req_ch.text_end;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Append the new word to the window and compare against the pattern
   always_comb begin
      cnt_cur = (SFR_CNT_W'(cnt_ff) >= plen_eff) ? '0 : cnt_ff;
      cnt_ext = SFR_CNT_W'(cnt_cur);
      n_len   = cnt_ext + SFR_CNT_W'(1);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         wprime[i] = (cnt_cur == CNT_W'(i)) ? in_byte_ff : win_ff[i];
      end
      hit = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((SFR_CNT_W'(i) < plen_eff) && (wprime[i] != pattern_ff[8*i +: 8])) begin
            hit = 1'b0;
         end
      end
      passing = done_ff && !every_ff;
      full    = !passing && (n_len == plen_eff);
   end

   // Build the burst of result words and the next window state
   always_comb begin
      ld.load       = 1'b0;
      ld.count      = '0;
      ld.byte_valid = 1'b1;
      ld.last       = in_end_ff;
      for (int i = 0; i < SFR_SLOTS; i++) begin
         ld.bytes[i] = (i < MAX_PATTERN) ? wprime[i % MAX_PATTERN] : '0;
      end
      win_in  = win_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;

      if (proc_fire) begin
         win_in = wprime;
         if (passing) begin
            ld.count = n_len;
            cnt_in   = '0;
         end else if (full && hit) begin
            for (int i = 0; i < SFR_SLOTS; i++) begin
               ld.bytes[i] = repl_ff[8*i +: 8];
            end
            ld.count = rlen_eff;
            cnt_in   = '0;
            done_in  = 1'b1;
         end else if (full) begin
            // Emit the oldest word (the whole window at end of text), slide the rest down
            ld.count = in_end_ff ? n_len : SFR_CNT_W'(1);
            for (int i = 0; i + 1 < MAX_PATTERN; i++) begin
               win_in[i] = wprime[i + 1];
            end
            cnt_in = cnt_cur;
         end else begin
            ld.count = in_end_ff ? n_len : '0;
            cnt_in   = CNT_W'(n_len);
         end

         // End of text: flush and close, with a marker if nothing went out
         if (in_end_ff) begin
            cnt_in  = '0;
            done_in = 1'b0;
            if (ld.count == '0) begin
               ld.count      = SFR_CNT_W'(1);
               ld.byte_valid = 1'b0;
               ld.bytes[0]   = '0;
            end
         end
         ld.load = (ld.count != '0);
      end

      if (csr_wr_en && (csr_index == CSR_PATTERN_LENGTH)) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         done_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
   end

   sfr_result_buffer u_result_buffer (
      .clock     (clock),
      .reset     (reset),
      .ld        (ld),
      .free_next (buf_free),
      .rsp_ch    (rsp_ch)
   );

`ifndef SYNTH
   // The window always holds fewer words than the pattern
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      SFR_CNT_W'(cnt_ff) < plen_eff)
      else $error("pending window reached the pattern length");

   // End of text empties the window and re-arms replacing
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_end_ff |=> (cnt_ff == '0) && !done_ff)
      else $error("state not cleared at end of text");

   // A held input word is not dropped
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_fire |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input word lost while stalled");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking bench for the stream find-and-replace unit: a driver and a
// monitor with random idling, and a byte-level predictor of the rewritten text.
// Depends on sfr_pkg, sfr_if and the stream_find_replace_unit RTL.
module tb_top;
   import sfr_pkg::*;

   localparam int PAT_MAX       = 8;
   localparam int REPL_MAX      = 8;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_PHASES = 8;
   localparam int RESET_CYCLES  = 7;

   typedef enum int {IDLE_NONE, IDLE_ALWAYS, IDLE_SOMETIMES} idle_mode_type;

   typedef struct packed {
      sfr_byte_type text_byte;
      logic         text_end;
   } text_word_type;

   typedef struct packed {
      sfr_byte_type out_byte;
      logic         byte_valid;
      logic         out_last;
   } out_word_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  req_valid   = 1'b0;
   sfr_byte_type          req_byte    = '0;
   logic                  req_end     = 1'b0;
   logic                  rsp_ready   = 1'b0;

   sfr_req_if req_ch();
   sfr_rsp_if rsp_ch();

   assign req_ch.valid     = req_valid;
   assign req_ch.text_byte = req_byte;
   assign req_ch.text_end  = req_end;
   assign rsp_ch.ready     = rsp_ready;

   stream_find_replace_unit #(
      .MAX_PATTERN     (PAT_MAX),
      .MAX_REPLACEMENT (REPL_MAX)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // Text words waiting to be driven, and result words owed by the unit
   text_word_type text_q [$];
   out_word_type  rewritten_q [$];

   // Shadow of the registers and of the pending window
   logic [CSR_DATA_W-1:0] pattern_r = '0;
   logic [3:0]            plen_r    = 4'd1;
   logic [CSR_DATA_W-1:0] repl_r    = '0;
   logic [3:0]            rlen_r    = 4'd0;
   logic                  every_r   = 1'b1;
   sfr_byte_type          window_r [PAT_MAX];
   int                    window_cnt = 0;
   logic                  replaced_r = 1'b0;

   idle_mode_type send_mode = IDLE_NONE;
   idle_mode_type recv_mode = IDLE_NONE;
   int            send_gap   = 0;
   int            recv_stall = 0;
   int            recv_wait  = 0;
   text_word_type drv_word;

   int words_sent       = 0;
   int results_seen     = 0;
   int texts_ended      = 0;
   int matches_replaced = 0;
   int settings_used    = 0;
   int errors           = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Effective pattern length: zero acts as one, oversize clips to the window
   function automatic int eff_pattern_len();
      if (plen_r == 0) return 1;
      if (plen_r > PAT_MAX) return PAT_MAX;
      return int'(plen_r);
   endfunction

   function automatic int draw_gap(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:   return 0;
         IDLE_ALWAYS: return $urandom_range(0, 15);
         default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("tb_top: mismatch at result %0d: %s", results_seen, what);
   endtask

   // Work out the result words caused by one accepted text word
   task automatic rewrite_text_byte(input sfr_byte_type b, input logic fin);
      out_word_type burst [2*PAT_MAX+REPL_MAX];
      int           n;
      int           plen;
      int           rlen;
      logic         hit;
      n    = 0;
      plen = eff_pattern_len();
      rlen = (rlen_r > REPL_MAX) ? REPL_MAX : int'(rlen_r);
      if (window_cnt >= plen) window_cnt = 0;
      window_r[window_cnt] = b;
      window_cnt++;
      if (replaced_r && !every_r) begin
         // first match already replaced: pass the window straight through
         for (int i = 0; i < window_cnt; i++) begin
            burst[n] = {window_r[i], 1'b1, 1'b0};
            n++;
         end
         window_cnt = 0;
      end else if (window_cnt == plen) begin
         hit = 1'b1;
         for (int i = 0; i < plen; i++)
            if (window_r[i] != pattern_r[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            for (int i = 0; i < rlen; i++) begin
               burst[n] = {repl_r[8*i +: 8], 1'b1, 1'b0};
               n++;
            end
            window_cnt = 0;
            replaced_r = 1'b1;
            matches_replaced++;
         end else begin
            // release the oldest byte and slide the window
            burst[n] = {window_r[0], 1'b1, 1'b0};
            n++;
            for (int i = 1; i < window_cnt; i++) window_r[i-1] = window_r[i];
            window_cnt--;
         end
      end
      if (fin) begin
         // flush at end of text, empty marker when nothing is left to emit
         for (int i = 0; i < window_cnt; i++) begin
            burst[n] = {window_r[i], 1'b1, 1'b0};
            n++;
         end
         if (n == 0) begin
            burst[n] = {8'h00, 1'b0, 1'b0};
            n++;
         end
         burst[n-1].out_last = 1'b1;
         window_cnt = 0;
         replaced_r = 1'b0;
         texts_ended++;
      end
      for (int i = 0; i < n; i++) rewritten_q.push_back(burst[i]);
   endtask

   task automatic check_result(input sfr_byte_type ob, input logic bv, input logic ol);
      out_word_type want;
      results_seen++;
      if (rewritten_q.size() == 0) begin
         report_mismatch($sformatf("unexpected word byte %02h valid %b last %b", ob, bv, ol));
      end else begin
         want = rewritten_q.pop_front();
         if (ob !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", ob, want.out_byte));
         if (bv !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %b, want %b", bv, want.byte_valid));
         if (ol !== want.out_last)
            report_mismatch($sformatf("out_last %b, want %b", ol, want.out_last));
      end
   endtask

   // Write one register while the unit is idle and mirror it in the shadow
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_SEARCH_PATTERN: pattern_r = value;
         CSR_PATTERN_LENGTH: begin
            plen_r     = value[3:0];
            window_cnt = 0;
         end
         CSR_REPLACEMENT_TEXT:   repl_r  = value;
         CSR_REPLACEMENT_LENGTH: rlen_r  = value[3:0];
         CSR_REPLACE_EVERY:      every_r = value[0];
         default: ;
      endcase
   endtask

   task automatic queue_word(input sfr_byte_type b, input logic e);
      text_q.push_back({b, e});
   endtask

   // Hold until every word is sent and every owed word has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (text_q.size() != 0 || req_valid || rewritten_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: predict on acceptance, then offer the next word after its gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ch.ready) begin
            rewrite_text_byte(req_byte, req_end);
            words_sent++;
         end
         if (!req_valid || req_ch.ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (text_q.size() != 0) begin
               drv_word  = text_q.pop_front();
               req_valid <= 1'b1;
               req_byte  <= drv_word.text_byte;
               req_end   <= drv_word.text_end;
               send_gap  <= draw_gap(send_mode);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result word, then stall for a drawn time
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall <= 0;
      end else begin
         recv_wait = recv_stall;
         if (rsp_ch.valid && rsp_ready) begin
            check_result(rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.out_last);
            recv_wait = draw_gap(recv_mode);
         end
         if (recv_wait != 0) begin
            rsp_ready  <= 1'b0;
            recv_stall <= recv_wait - 1;
         end else begin
            rsp_ready  <= 1'b1;
            recv_stall <= 0;
         end
      end
   end

   initial begin
      sfr_byte_type          alpha [3];
      logic [CSR_DATA_W-1:0] wide;
      sfr_byte_type          b;
      logic                  fin;
      int                    phase_goal;
      int                    queued;
      int                    text_goal;
      int                    text_len;
      int                    kind;
      int                    chunk_n;
      int                    eplen;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a single zero byte is deleted, empty end markers appear
      settings_used++;
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b1);
      queue_word(8'h00, 1'b1);
      queue_word(8'h5A, 1'b1);
      wait_idle();

      // Three-byte pattern, oversize replacement, first match only
      settings_used++;
      write_csr(CSR_SEARCH_PATTERN, 64'hDEAD_BEEF_0043_4241);
      write_csr(CSR_PATTERN_LENGTH, 64'd3);
      write_csr(CSR_REPLACEMENT_TEXT, 64'h0123_4567_89AB_CDEF);
      write_csr(CSR_REPLACEMENT_LENGTH, 64'd15);
      write_csr(CSR_REPLACE_EVERY, 64'd0);
      send_mode = IDLE_ALWAYS;
      recv_mode = IDLE_ALWAYS;
      queue_word(8'h41, 1'b0);
      queue_word(8'h42, 1'b0);
      queue_word(8'h43, 1'b0);
      queue_word(8'h41, 1'b0);
      queue_word(8'h42, 1'b0);
      queue_word(8'h43, 1'b1);
      queue_word(8'h41, 1'b0);
      queue_word(8'h41, 1'b0);
      queue_word(8'h42, 1'b0);
      queue_word(8'h43, 1'b1);
      queue_word(8'h41, 1'b0);
      queue_word(8'h42, 1'b1);
      wait_idle();

      // Rewrite the pattern length with bytes held mid-text: the window is dropped
      settings_used++;
      write_csr(CSR_SEARCH_PATTERN, 64'hFFFF_FFFF_00FF_00FF);
      write_csr(CSR_PATTERN_LENGTH, 64'd4);
      write_csr(CSR_REPLACE_EVERY, 64'd1);
      send_mode = IDLE_SOMETIMES;
      recv_mode = IDLE_NONE;
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b0);
      wait_idle();
      write_csr(CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF8);
      queue_word(8'hFF, 1'b1);
      wait_idle();

      // Zero pattern length acts as one; unused register indexes are ignored
      settings_used++;
      write_csr(CSR_PATTERN_LENGTH, 64'hA5A5_0000_0000_0000);
      write_csr(CSR_REPLACEMENT_LENGTH, 64'd0);
      for (int k = int'(CSR_REPLACE_EVERY) + 1; k < (1 << CSR_IDX_W); k++)
         write_csr(CSR_IDX_W'(k), '1);
      queue_word(8'hFF, 1'b0);
      queue_word(8'hFF, 1'b1);
      wait_idle();

      // Random phases: texts built mostly from the pattern, its prefixes and
      // a small alphabet, with full-range noise bytes mixed in
      text_len  = 0;
      text_goal = $urandom_range(1, 24);
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settings_used++;
         foreach (alpha[i]) alpha[i] = sfr_byte_type'($urandom_range(0, 255));
         if (p % 3 == 0) begin
            alpha[0] = 8'h00;
            alpha[1] = 8'hFF;
         end
         for (int i = 0; i < PAT_MAX; i++) wide[8*i +: 8] = alpha[$urandom_range(0, 2)];
         if (p == 1) wide = '1;
         if (p < 2 || $urandom_range(0, 3) != 0) write_csr(CSR_SEARCH_PATTERN, wide);

         case ($urandom_range(0, 5))
            0:       wide = 64'd1;
            1:       wide = 64'd8;
            2:       wide = {$urandom, $urandom};
            default: wide = 64'($urandom_range(2, 7));
         endcase
         if (p == RANDOM_PHASES - 1) wide = 64'd8;
         if (p == 0 || $urandom_range(0, 3) != 0) write_csr(CSR_PATTERN_LENGTH, wide);

         if (p == 0 || $urandom_range(0, 3) != 0)
            write_csr(CSR_REPLACEMENT_TEXT, {$urandom, $urandom});

         wide = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(9, 15))
                                            : 64'($urandom_range(0, 8));
         if (p == RANDOM_PHASES - 1) wide = 64'd8;
         if (p == 0 || $urandom_range(0, 3) != 0) write_csr(CSR_REPLACEMENT_LENGTH, wide);

         if (p == 0 || $urandom_range(0, 3) != 0)
            write_csr(CSR_REPLACE_EVERY, 64'($urandom_range(0, 1)));

         send_mode = idle_mode_type'($urandom_range(0, 2));
         recv_mode = idle_mode_type'($urandom_range(0, 2));
         eplen      = eff_pattern_len();
         phase_goal = $urandom_range(35, 65);
         queued     = 0;
         while (queued < phase_goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) chunk_n = eplen;
            else if (kind < 60) chunk_n = (eplen > 1) ? $urandom_range(1, eplen - 1) : 1;
            else chunk_n = 1;
            for (int k = 0; k < chunk_n; k++) begin
               if (kind < 60) b = pattern_r[8*k +: 8];
               else if (kind < 85) b = alpha[$urandom_range(0, 2)];
               else b = sfr_byte_type'($urandom_range(0, 255));
               text_len++;
               fin = (text_len >= text_goal);
               queue_word(b, fin);
               queued++;
               if (fin) begin
                  text_len  = 0;
                  text_goal = $urandom_range(1, 24);
               end
            end
            // now and then hold the sender until everything owed has come out
            if (kind == 99) wait_idle();
         end
         wait_idle();
      end

      $display("tb_top: %0d text words over %0d register settings gave %0d result words",
               words_sent, settings_used, results_seen);
      $display("tb_top: %0d texts closed, %0d matches replaced, %0d mismatches",
               texts_ended, matches_replaced, errors);
      if (errors == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("tb_top: watchdog expired, %0d words still owed", rewritten_q.size());
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
